@@ hdl/dmlo_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, codes and control structures of the density matrix operator block
package dmlo_pkg;

    localparam int MAX_DIM     = 64;
    localparam int MAX_SITES   = 6;
    localparam int MAX_OP_DIM  = 9;
    localparam int MAX_TARGETS = 3;
    localparam int FRAC_BITS   = 29;

    localparam int DATA_W     = 32;
    localparam int IDX_W      = $clog2(MAX_DIM);
    localparam int MAT_AW     = 2 * IDX_W;
    localparam int MAT_DEPTH  = MAX_DIM * MAX_DIM;
    localparam int OPM_DEPTH  = MAX_OP_DIM * MAX_OP_DIM;
    localparam int OPM_AW     = $clog2(OPM_DEPTH);
    localparam int LANE_W     = $clog2(MAX_OP_DIM + 1);
    localparam int PROD_W     = 2 * DATA_W;
    localparam int TERM_W     = PROD_W + 1 - FRAC_BITS;
    localparam int ACC_W      = TERM_W + 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    typedef enum logic [1:0] {
        OP_WR_MAT = 2'd0,
        OP_WR_OP  = 2'd1,
        OP_APPLY  = 2'd2,
        OP_RD_MAT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_BADCFG = 2'd2,
        ST_SAT    = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QMASK  = 3'd0,
        CFG_SITES  = 3'd1,
        CFG_TLIST  = 3'd2,
        CFG_TCOUNT = 3'd3,
        CFG_CMASK  = 3'd4,
        CFG_SIDE   = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_WAIT,
        S_SCAN,
        S_LOAD,
        S_LOAD_LAST,
        S_MAC,
        S_MAC_END,
        S_SAT,
        S_WRITE,
        S_FIN
    } state_t;

    typedef struct packed {
        logic                                 side;
        logic                                 dim_ok;
        logic                                 apply_ok;
        logic [IDX_W:0]                       dim;
        logic [LANE_W-1:0]                    m;
        logic [MAX_SITES-1:0]                 tmask;
        logic [MAX_SITES-1:0]                 cmask;
        logic [MAX_SITES-1:0]                 qmask;
        logic [2:0]                           site_count;
        logic [MAX_OP_DIM-1:0][IDX_W-1:0]     off;
    } cfg_t;

    typedef struct packed {
        logic                 mat_rd;
        logic                 mat_wr;
        logic                 mat_wsel;
        logic [MAT_AW-1:0]    mat_addr;
        logic                 opm_rd;
        logic                 opm_wr;
        logic [OPM_AW-1:0]    opm_addr;
        logic                 vr_load;
        logic [LANE_W-1:0]    vr_lane;
        logic                 mul_en;
        logic [1:0]           mul_k;
        logic [LANE_W-1:0]    mul_lane;
        logic                 acc_clr;
        logic                 sat_en;
        logic [LANE_W-1:0]    rr_lane;
        logic                 flag_clr;
        logic                 out_load;
        logic                 out_rd;
        status_t              out_status;
    } cmd_t;

    typedef struct packed {
        logic sat_flag;
        logic slot_free;
    } dp_stat_t;

endpackage

@@ hdl/dmlo_if.sv @@
`timescale 1ns / 1ps
// request, response and configuration channel interfaces
interface dmlo_req_if import dmlo_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               op;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [DATA_W-1:0] value_real;
    logic signed [DATA_W-1:0] value_imag;

    modport source (output valid, op, row_index, col_index, value_real, value_imag,
                    input ready);
    modport sink   (input valid, op, row_index, col_index, value_real, value_imag,
                    output ready);
endinterface

interface dmlo_rsp_if import dmlo_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] read_real;
    logic signed [DATA_W-1:0] read_imag;
    logic [1:0]               status;

    modport source (output valid, read_real, read_imag, status, input ready);
    modport sink   (input valid, read_real, read_imag, status, output ready);
endinterface

interface dmlo_cfg_if import dmlo_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/dmlo_cfg.sv @@
`timescale 1ns / 1ps
// configuration registers and derived geometry and checks
module dmlo_cfg import dmlo_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    dmlo_cfg_if.sink   cfg,
    output cfg_t       cfg_info
);

    localparam int DIM_W = 10;

    logic [MAX_SITES-1:0] qmask_reg;
    logic [2:0]           sites_reg;
    logic [8:0]           tlist_reg;
    logic [1:0]           tcount_reg;
    logic [MAX_SITES-1:0] cmask_reg;
    logic                 side_reg;

    function automatic logic [3:0] div3(input logic [3:0] v);
        logic [8:0] p;
        p = 9'(v) * 9'd11;
        return p[8:5];
    endfunction

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qmask_reg  <= '0;
            sites_reg  <= 3'd1;
            tlist_reg  <= '0;
            tcount_reg <= 2'd1;
            cmask_reg  <= '0;
            side_reg   <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_QMASK:  qmask_reg  <= cfg.data[MAX_SITES-1:0];
                CFG_SITES:  sites_reg  <= cfg.data[2:0];
                CFG_TLIST:  tlist_reg  <= cfg.data[8:0];
                CFG_TCOUNT: tcount_reg <= cfg.data[1:0];
                CFG_CMASK:  cmask_reg  <= cfg.data[MAX_SITES-1:0];
                CFG_SIDE:   side_reg   <= cfg.data[0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        logic [DIM_W-1:0]         d;
        logic [7:0][DIM_W-1:0]    stride;
        logic [7:0]               qm8;
        logic [7:0]               tm8;
        logic [4:0]               m;
        logic                     bad;
        logic [2:0]               t;
        logic [3:0]               r;
        logic [3:0]               q;
        logic [3:0]               dig;
        logic [DIM_W-1:0]         o;

        q      = '0;
        dig    = '0;
        t      = '0;
        qm8    = {2'b00, qmask_reg};
        stride = '0;
        d      = DIM_W'(1);
        for (int s = 0; s < MAX_SITES; s++)
        begin
            stride[s] = d;
            if (s < sites_reg)
                d = qmask_reg[s] ? DIM_W'(d + (d << 1)) : DIM_W'(d << 1);
        end

        tm8 = '0;
        m   = 5'd1;
        bad = (tcount_reg == 2'd0) || (tcount_reg > 2'(MAX_TARGETS));
        for (int j = 0; j < MAX_TARGETS; j++)
        begin
            t = tlist_reg[3*j +: 3];
            if (j < tcount_reg)
            begin
                if (t >= sites_reg || tm8[t])
                    bad = 1'b1;
                tm8[t] = 1'b1;
                m = qm8[t] ? 5'(m * 5'd3) : 5'(m << 1);
            end
        end

        cfg_info.off = '0;
        for (int l = 0; l < MAX_OP_DIM; l++)
        begin
            r = 4'(l);
            o = '0;
            for (int j = 0; j < MAX_TARGETS; j++)
            begin
                t = tlist_reg[3*j +: 3];
                if (j < tcount_reg)
                begin
                    if (qm8[t])
                    begin
                        q   = div3(r);
                        dig = 4'(r - 4'(q + (q << 1)));
                    end
                    else
                    begin
                        q   = r >> 1;
                        dig = {3'b000, r[0]};
                    end
                    if (dig == 4'd1)
                        o = DIM_W'(o + stride[t]);
                    else if (dig == 4'd2)
                        o = DIM_W'(o + (stride[t] << 1));
                    r = q;
                end
            end
            cfg_info.off[l] = o[IDX_W-1:0];
        end

        cfg_info.side       = side_reg;
        cfg_info.dim_ok     = (sites_reg != 3'd0) && (sites_reg <= 3'(MAX_SITES))
                              && (d <= DIM_W'(MAX_DIM));
        cfg_info.apply_ok   = cfg_info.dim_ok && !bad && (m <= 5'(MAX_OP_DIM))
                              && ((cmask_reg >> sites_reg) == '0);
        cfg_info.dim        = d[IDX_W:0];
        cfg_info.m          = m[LANE_W-1:0];
        cfg_info.tmask      = tm8[MAX_SITES-1:0];
        cfg_info.cmask      = cmask_reg;
        cfg_info.qmask      = qmask_reg;
        cfg_info.site_count = sites_reg;
    end

endmodule

@@ hdl/dmlo_ctrl.sv @@
`timescale 1ns / 1ps
// controller state machine with group, line, lane and phase counters
module dmlo_ctrl import dmlo_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    dmlo_req_if.sink   req,
    input  cfg_t       ci,
    input  dp_stat_t   st,
    output cmd_t       cmd
);

    localparam logic [2:0] PH_LAST = 3'd4;

    state_t                     state_reg, state_next;
    logic [MAX_SITES-1:0][1:0]  dig_reg, dig_next, dig_inc;
    logic [IDX_W-1:0]           i_reg, i_next;
    logic [IDX_W-1:0]           line_reg, line_next;
    logic [LANE_W-1:0]          l_reg, l_next;
    logic [LANE_W-1:0]          a_reg, a_next;
    logic [2:0]                 ph_reg, ph_next;

    op_t              op;
    logic             accept;
    logic             mat_idx_ok;
    logic             opm_idx_ok;
    logic [IDX_W-1:0] pos;
    logic [MAT_AW-1:0] apply_addr;
    logic             take;
    logic             i_last;
    logic             line_last;
    logic             l_last;
    logic             carry;

    assign op         = op_t'(req.op);
    assign req.ready  = (state_reg == S_IDLE) && st.slot_free;
    assign accept     = req.valid && req.ready;
    assign mat_idx_ok = ({1'b0, req.row_index} < ci.dim) && ({1'b0, req.col_index} < ci.dim);
    assign opm_idx_ok = (req.row_index < IDX_W'(MAX_OP_DIM))
                        && (req.col_index < IDX_W'(MAX_OP_DIM));
    assign pos        = IDX_W'(i_reg + ci.off[l_reg]);
    assign apply_addr = ci.side ? {line_reg, pos} : {pos, line_reg};
    assign i_last     = (i_reg == IDX_W'(ci.dim - 1'b1));
    assign line_last  = (line_reg == IDX_W'(ci.dim - 1'b1));
    assign l_last     = (l_reg == LANE_W'(ci.m - 1'b1));

    // group base test and mixed-radix increment
    always_comb
    begin
        take    = 1'b1;
        carry   = 1'b1;
        dig_inc = dig_reg;
        for (int s = 0; s < MAX_SITES; s++)
        begin
            if (s < ci.site_count)
            begin
                if (ci.tmask[s] && dig_reg[s] != 2'd0)
                    take = 1'b0;
                if (ci.cmask[s] && dig_reg[s] != 2'd1)
                    take = 1'b0;
                if (carry)
                begin
                    if (dig_reg[s] == (ci.qmask[s] ? 2'd2 : 2'd1))
                        dig_inc[s] = 2'd0;
                    else
                    begin
                        dig_inc[s] = dig_reg[s] + 2'd1;
                        carry      = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dig_reg   <= '0;
            i_reg     <= '0;
            line_reg  <= '0;
            l_reg     <= '0;
            a_reg     <= '0;
            ph_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dig_reg   <= dig_next;
            i_reg     <= i_next;
            line_reg  <= line_next;
            l_reg     <= l_next;
            a_reg     <= a_next;
            ph_reg    <= ph_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dig_next   = dig_reg;
        i_next     = i_reg;
        line_next  = line_reg;
        l_next     = l_reg;
        a_next     = a_reg;
        ph_next    = ph_reg;

        cmd          = '0;
        cmd.mat_addr = apply_addr;
        cmd.opm_addr = OPM_AW'(a_reg * MAX_OP_DIM + l_reg);
        cmd.vr_lane  = LANE_W'(l_reg - 1'b1);
        cmd.mul_lane = l_reg;
        cmd.mul_k    = 2'(ph_reg - 3'd1);
        cmd.rr_lane  = (state_reg == S_SAT) ? a_reg : l_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd.mat_addr = {req.row_index, req.col_index};
                cmd.opm_addr = OPM_AW'(req.row_index * MAX_OP_DIM + req.col_index);
                if (accept)
                begin
                    unique case (op)
                        OP_WR_OP:
                        begin
                            cmd.out_load = 1'b1;
                            if (opm_idx_ok)
                                cmd.opm_wr = 1'b1;
                            else
                                cmd.out_status = ST_RANGE;
                        end
                        OP_WR_MAT:
                        begin
                            cmd.out_load = 1'b1;
                            if (!ci.dim_ok)
                                cmd.out_status = ST_BADCFG;
                            else if (!mat_idx_ok)
                                cmd.out_status = ST_RANGE;
                            else
                            begin
                                cmd.mat_wr   = 1'b1;
                                cmd.mat_wsel = 1'b1;
                            end
                        end
                        OP_RD_MAT:
                        begin
                            if (!ci.dim_ok)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = ST_BADCFG;
                            end
                            else if (!mat_idx_ok)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = ST_RANGE;
                            end
                            else
                            begin
                                cmd.mat_rd = 1'b1;
                                state_next = S_RD_WAIT;
                            end
                        end
                        OP_APPLY:
                        begin
                            if (!ci.apply_ok)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = ST_BADCFG;
                            end
                            else
                            begin
                                cmd.flag_clr = 1'b1;
                                dig_next     = '0;
                                i_next       = '0;
                                state_next   = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD_WAIT:
            begin
                if (st.slot_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_rd   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (take)
                begin
                    line_next  = '0;
                    l_next     = '0;
                    state_next = S_LOAD;
                end
                else if (i_last)
                    state_next = S_FIN;
                else
                begin
                    i_next   = IDX_W'(i_reg + 1'b1);
                    dig_next = dig_inc;
                end
            end
            S_LOAD:
            begin
                cmd.mat_rd  = 1'b1;
                cmd.vr_load = (l_reg != '0);
                if (l_last)
                    state_next = S_LOAD_LAST;
                else
                    l_next = LANE_W'(l_reg + 1'b1);
            end
            S_LOAD_LAST:
            begin
                cmd.vr_load = 1'b1;
                cmd.vr_lane = l_reg;
                cmd.acc_clr = 1'b1;
                a_next      = '0;
                l_next      = '0;
                ph_next     = '0;
                state_next  = S_MAC;
            end
            S_MAC:
            begin
                if (ph_reg == 3'd0)
                begin
                    cmd.opm_rd = 1'b1;
                    ph_next    = 3'd1;
                end
                else
                begin
                    cmd.mul_en = 1'b1;
                    if (ph_reg == PH_LAST)
                    begin
                        ph_next = '0;
                        if (l_last)
                            state_next = S_MAC_END;
                        else
                            l_next = LANE_W'(l_reg + 1'b1);
                    end
                    else
                        ph_next = 3'(ph_reg + 3'd1);
                end
            end
            S_MAC_END:
            begin
                state_next = S_SAT;
            end
            S_SAT:
            begin
                cmd.sat_en  = 1'b1;
                cmd.acc_clr = 1'b1;
                l_next      = '0;
                ph_next     = '0;
                if (a_reg == LANE_W'(ci.m - 1'b1))
                    state_next = S_WRITE;
                else
                begin
                    a_next     = LANE_W'(a_reg + 1'b1);
                    state_next = S_MAC;
                end
            end
            S_WRITE:
            begin
                cmd.mat_wr = 1'b1;
                if (l_last)
                begin
                    l_next = '0;
                    if (!line_last)
                    begin
                        line_next  = IDX_W'(line_reg + 1'b1);
                        state_next = S_LOAD;
                    end
                    else if (i_last)
                        state_next = S_FIN;
                    else
                    begin
                        i_next     = IDX_W'(i_reg + 1'b1);
                        dig_next   = dig_inc;
                        state_next = S_SCAN;
                    end
                end
                else
                    l_next = LANE_W'(l_reg + 1'b1);
            end
            S_FIN:
            begin
                if (st.slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = st.sat_flag ? ST_SAT : ST_OK;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_lane_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC) |-> ((l_reg < ci.m) && (a_reg < ci.m)))
        else $error("operator lane counter beyond operator size");

    a_mat_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.mat_rd && cmd.mat_wr))
        else $error("matrix store read and written in one cycle");

    a_wr_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> ({1'b0, pos} < ci.dim))
        else $error("apply write position beyond matrix dimension");

endmodule

@@ hdl/dmlo_dp.sv @@
`timescale 1ns / 1ps
// datapath: matrix and operator stores, lane registers, multiply-accumulate, result register
module dmlo_dp import dmlo_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    input  logic                     side,
    input  logic signed [DATA_W-1:0] wr_real,
    input  logic signed [DATA_W-1:0] wr_imag,
    output dp_stat_t                 st,
    dmlo_rsp_if.source               rsp
);

    logic [PROD_W-1:0] mat_mem [MAT_DEPTH];
    logic [PROD_W-1:0] opm_mem [OPM_DEPTH];
    logic [PROD_W-1:0] mat_dout_reg;
    logic [PROD_W-1:0] opm_dout_reg;

    logic signed [DATA_W-1:0] vr_re_reg [MAX_OP_DIM];
    logic signed [DATA_W-1:0] vr_im_reg [MAX_OP_DIM];
    logic signed [DATA_W-1:0] rr_re_reg [MAX_OP_DIM];
    logic signed [DATA_W-1:0] rr_im_reg [MAX_OP_DIM];

    logic signed [PROD_W-1:0] mul_reg;
    logic [1:0]               mul_k_reg;
    logic                     mul_valid_reg;
    logic signed [ACC_W-1:0]  acc_re_reg;
    logic signed [ACC_W-1:0]  acc_im_reg;
    logic                     flag_reg;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_re_reg;
    logic signed [DATA_W-1:0] out_im_reg;
    status_t                  out_status_reg;

    logic [PROD_W-1:0]        mat_wdata;
    logic signed [DATA_W-1:0] mx;
    logic signed [DATA_W-1:0] my;
    logic signed [PROD_W:0]   rnd;
    logic signed [TERM_W-1:0] term;
    logic signed [ACC_W-1:0]  term_ext;
    logic                     term_neg;
    logic [DATA_W:0]          sat_re;
    logic [DATA_W:0]          sat_im;

    function automatic logic [DATA_W:0] sat32(input logic signed [ACC_W-1:0] v);
        logic fits;
        fits = (v[ACC_W-1:DATA_W-1] == '0) || (v[ACC_W-1:DATA_W-1] == '1);
        if (fits)
            return {1'b0, v[DATA_W-1:0]};
        else if (v[ACC_W-1])
            return {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
        else
            return {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
    endfunction

    assign mat_wdata = cmd.mat_wsel ? {wr_imag, wr_real}
                                    : {rr_im_reg[cmd.rr_lane], rr_re_reg[cmd.rr_lane]};

    always_ff @(posedge clk)
    begin
        if (cmd.mat_wr)
            mat_mem[cmd.mat_addr] <= mat_wdata;
        if (cmd.mat_rd)
            mat_dout_reg <= mat_mem[cmd.mat_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.opm_wr)
            opm_mem[cmd.opm_addr] <= {wr_imag, wr_real};
        if (cmd.opm_rd)
            opm_dout_reg <= opm_mem[cmd.opm_addr];
    end

    // operand select: even phases take the real operator part, phases 1 and 2 the imaginary lane
    assign mx = cmd.mul_k[0] ? signed'(opm_dout_reg[PROD_W-1:DATA_W])
                             : signed'(opm_dout_reg[DATA_W-1:0]);
    assign my = (cmd.mul_k[0] ^ cmd.mul_k[1]) ? vr_im_reg[cmd.mul_lane]
                                              : vr_re_reg[cmd.mul_lane];

    assign rnd      = {mul_reg[PROD_W-1], mul_reg}
                      + {{(PROD_W-FRAC_BITS+1){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    assign term     = rnd[PROD_W:FRAC_BITS];
    assign term_ext = {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};
    assign term_neg = side ? (mul_k_reg == 2'd3) : (mul_k_reg == 2'd1);
    assign sat_re   = sat32(acc_re_reg);
    assign sat_im   = sat32(acc_im_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.vr_load)
        begin
            vr_re_reg[cmd.vr_lane] <= mat_dout_reg[DATA_W-1:0];
            vr_im_reg[cmd.vr_lane] <= mat_dout_reg[PROD_W-1:DATA_W];
        end
        if (cmd.mul_en)
        begin
            mul_reg   <= mx * my;
            mul_k_reg <= cmd.mul_k;
        end
        if (cmd.sat_en)
        begin
            rr_re_reg[cmd.rr_lane] <= sat_re[DATA_W-1:0];
            rr_im_reg[cmd.rr_lane] <= sat_im[DATA_W-1:0];
        end
        if (cmd.acc_clr)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (mul_valid_reg)
        begin
            if (!mul_k_reg[1])
                acc_re_reg <= term_neg ? ACC_W'(acc_re_reg - term_ext)
                                       : ACC_W'(acc_re_reg + term_ext);
            else
                acc_im_reg <= term_neg ? ACC_W'(acc_im_reg - term_ext)
                                       : ACC_W'(acc_im_reg + term_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= cmd.mul_en;
            if (cmd.flag_clr)
                flag_reg <= 1'b0;
            else if (cmd.sat_en && (sat_re[DATA_W] || sat_im[DATA_W]))
                flag_reg <= 1'b1;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_re_reg     <= cmd.out_rd ? signed'(mat_dout_reg[DATA_W-1:0]) : '0;
            out_im_reg     <= cmd.out_rd ? signed'(mat_dout_reg[PROD_W-1:DATA_W]) : '0;
            out_status_reg <= cmd.out_status;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_real = out_re_reg;
    assign rsp.read_imag = out_im_reg;
    assign rsp.status    = out_status_reg;

    assign st.sat_flag  = flag_reg;
    assign st.slot_free = !out_valid_reg || rsp.ready;

endmodule

@@ hdl/density_matrix_local_operator.sv @@
`timescale 1ns / 1ps
// top level: matrix and operator element loads, readback, controlled local operator apply
// element writes and all errors respond in the cycle after the request; reads pass the store
// read register first. apply scans all D (matrix dimension) group bases; per selected group and
// line it loads m (operator size) lanes, multiplies on one shared 32x32 multiplier, writes m back
// one request in flight; a new request is taken no earlier than the cycle the last response is taken
// reset: configuration to its reset values, control cleared; stores hold no value until written
module density_matrix_local_operator import dmlo_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    dmlo_req_if.sink    req,
    dmlo_rsp_if.source  rsp,
    dmlo_cfg_if.sink    cfg
);

    cfg_t     cfg_info;
    cmd_t     cmd;
    dp_stat_t dp_stat;

    dmlo_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_info (cfg_info)
    );

    dmlo_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .ci    (cfg_info),
        .st    (dp_stat),
        .cmd   (cmd)
    );

    dmlo_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .side    (cfg_info.side),
        .wr_real (req.value_real),
        .wr_imag (req.value_imag),
        .st      (dp_stat),
        .rsp     (rsp)
    );

endmodule
